@@ rtl/hsvrgb_pkg.sv @@
package hsvrgb_pkg;

  // Field widths
  localparam int HueW   = 16;
  localparam int PctW   = 7;
  localparam int LevelW = 8;
  localparam int OffW   = 6;
  localparam int RemW   = 9;

  // Scale constants
  localparam logic [PctW-1:0] PCT_FULL = 7'd100;

  // floor(x/360) = (x * 11651) >> 22, exact for 16-bit x
  localparam logic [13:0] HUE_RECIP = 14'd11651;
  localparam int          HUE_SHIFT = 22;

  // floor(x/100) = (x * 5243) >> 19, exact for x <= 25500
  localparam logic [12:0] PCT_RECIP = 13'd5243;
  localparam int          PCT_SHIFT = 19;

  // floor(x/60) = (x * 17477) >> 20, exact for x <= 15045
  localparam logic [14:0] SEC_RECIP = 15'd17477;
  localparam int          SEC_SHIFT = 20;

  // Hue sector boundaries in degrees
  localparam logic [RemW-1:0] SEC1_BASE = 9'd60;
  localparam logic [RemW-1:0] SEC2_BASE = 9'd120;
  localparam logic [RemW-1:0] SEC3_BASE = 9'd180;
  localparam logic [RemW-1:0] SEC4_BASE = 9'd240;
  localparam logic [RemW-1:0] SEC5_BASE = 9'd300;

  // 60-degree hue sectors
  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_t;

  // Transfer from the level/hue front end to the mixing back end
  typedef struct packed {
    logic              valid;
    logic [LevelW-1:0] top;
    logic [LevelW-1:0] bot;
    sector_t           sector;
    logic [OffW-1:0]   offset;
  } front_out_t;

endpackage

@@ rtl/hsvrgb_front.sv @@
module hsvrgb_front
  import hsvrgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [HueW-1:0]   hue_degrees,
  input  logic [PctW-1:0]   saturation_pct,
  input  logic [PctW-1:0]   value_pct,
  output front_out_t        front_out
);

  // ---------------- stage 1: clamp, hue quotient, max level
  logic              s1_valid;
  logic [HueW-1:0]   s1_hue;
  logic [7:0]        s1_quot;
  logic [LevelW-1:0] s1_top;
  logic [PctW-1:0]   s1_inv_sat;

  logic [PctW-1:0]   sat_c;
  logic [PctW-1:0]   val_c;
  logic [14:0]       val_255;
  logic [29:0]       hue_prod;
  logic [26:0]       top_prod;

  always_comb begin
    sat_c    = (saturation_pct > PCT_FULL) ? PCT_FULL : saturation_pct;
    val_c    = (value_pct > PCT_FULL) ? PCT_FULL : value_pct;
    val_255  = {val_c, 8'b0} - 15'(val_c);
    hue_prod = 30'(hue_degrees) * 30'(HUE_RECIP);
    top_prod = 27'(val_255) * 27'(PCT_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_hue     <= hue_degrees;
    s1_quot    <= hue_prod[HUE_SHIFT +: 8];
    s1_top     <= top_prod[PCT_SHIFT +: LevelW];
    s1_inv_sat <= PCT_FULL - sat_c;
  end

  // ---------------- stage 2: hue mod 360, min level product
  logic              s2_valid;
  logic [RemW-1:0]   s2_rem;
  logic [LevelW-1:0] s2_top;
  logic [14:0]       s2_bot_prod;

  logic [HueW-1:0]   quot_360;
  logic [HueW-1:0]   rem_full;

  always_comb begin
    // 360 = 256 + 64 + 32 + 8
    quot_360 = (16'(s1_quot) << 8) + (16'(s1_quot) << 6)
             + (16'(s1_quot) << 5) + (16'(s1_quot) << 3);
    rem_full = s1_hue - quot_360;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_rem      <= rem_full[RemW-1:0];
    s2_top      <= s1_top;
    s2_bot_prod <= 15'(s1_top) * 15'(s1_inv_sat);
  end

  // ---------------- stage 3: min level, sector and offset
  logic [27:0]     bot_full;
  sector_t         sector_c;
  logic [RemW-1:0] base_c;
  logic [RemW-1:0] off_full;

  always_comb begin
    bot_full = 28'(s2_bot_prod) * 28'(PCT_RECIP);
    if (s2_rem >= SEC5_BASE) begin
      sector_c = SEC_MAG_RED;
      base_c   = SEC5_BASE;
    end else if (s2_rem >= SEC4_BASE) begin
      sector_c = SEC_BLU_MAG;
      base_c   = SEC4_BASE;
    end else if (s2_rem >= SEC3_BASE) begin
      sector_c = SEC_CYN_BLU;
      base_c   = SEC3_BASE;
    end else if (s2_rem >= SEC2_BASE) begin
      sector_c = SEC_GRN_CYN;
      base_c   = SEC2_BASE;
    end else if (s2_rem >= SEC1_BASE) begin
      sector_c = SEC_YEL_GRN;
      base_c   = SEC1_BASE;
    end else begin
      sector_c = SEC_RED_YEL;
      base_c   = '0;
    end
    off_full = s2_rem - base_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_out.valid <= 1'b0;
    end else begin
      front_out.valid <= s2_valid;
    end
    front_out.top    <= s2_top;
    front_out.bot    <= bot_full[PCT_SHIFT +: LevelW];
    front_out.sector <= sector_c;
    front_out.offset <= off_full[OffW-1:0];
  end

endmodule

@@ rtl/hsvrgb_mix.sv @@
module hsvrgb_mix
  import hsvrgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  front_out_t        front_in,
  output logic              done,
  output logic [LevelW-1:0] red_level,
  output logic [LevelW-1:0] green_level,
  output logic [LevelW-1:0] blue_level
);

  // ---------------- stage 4: span times offset
  logic              s4_valid;
  logic [LevelW-1:0] s4_top;
  logic [LevelW-1:0] s4_bot;
  sector_t           s4_sector;
  logic [13:0]       s4_ramp_prod;

  logic [LevelW-1:0] span;

  assign span = front_in.top - front_in.bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= front_in.valid;
    end
    s4_top       <= front_in.top;
    s4_bot       <= front_in.bot;
    s4_sector    <= front_in.sector;
    s4_ramp_prod <= 14'(span) * 14'(front_in.offset);
  end

  // ---------------- stage 5: ramp = product / 60
  logic              s5_valid;
  logic [LevelW-1:0] s5_top;
  logic [LevelW-1:0] s5_bot;
  sector_t           s5_sector;
  logic [LevelW-1:0] s5_ramp;

  logic [28:0]       ramp_full;

  assign ramp_full = 29'(s4_ramp_prod) * 29'(SEC_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_top    <= s4_top;
    s5_bot    <= s4_bot;
    s5_sector <= s4_sector;
    s5_ramp   <= ramp_full[SEC_SHIFT +: LevelW];
  end

  // ---------------- stage 6: six-way channel select
  logic [LevelW-1:0] up;
  logic [LevelW-1:0] down;
  logic [LevelW-1:0] red_next;
  logic [LevelW-1:0] green_next;
  logic [LevelW-1:0] blue_next;

  always_comb begin
    up   = s5_bot + s5_ramp;
    down = s5_top - s5_ramp;
    case (s5_sector)
      SEC_RED_YEL: begin
        red_next = s5_top; green_next = up;     blue_next = s5_bot;
      end
      SEC_YEL_GRN: begin
        red_next = down;   green_next = s5_top; blue_next = s5_bot;
      end
      SEC_GRN_CYN: begin
        red_next = s5_bot; green_next = s5_top; blue_next = up;
      end
      SEC_CYN_BLU: begin
        red_next = s5_bot; green_next = down;   blue_next = s5_top;
      end
      SEC_BLU_MAG: begin
        red_next = up;     green_next = s5_bot; blue_next = s5_top;
      end
      default: begin
        red_next = s5_top; green_next = s5_bot; blue_next = down;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s5_valid;
    end
    red_level   <= red_next;
    green_level <= green_next;
    blue_level  <= blue_next;
  end

endmodule

@@ rtl/hsv_to_rgb_converter.sv @@
// Channel   Transfer when        Signals
// input     start && !busy       hue_degrees, saturation_pct, value_pct
// result    done (one cycle)     red_level, green_level, blue_level
//
// One item may start every cycle; each passes through the six register stages
// around the reciprocal multipliers (hue / 360, level / 100 twice, ramp / 60)
// and the final select on its way from start to done.
// busy stays low: the pipeline never stalls since results cannot be held off.
// Synchronous reset clears the valid bits only; items in flight are dropped.
module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [HueW-1:0]   hue_degrees,
  input  logic [PctW-1:0]   saturation_pct,
  input  logic [PctW-1:0]   value_pct,
  output logic              done,
  output logic [LevelW-1:0] red_level,
  output logic [LevelW-1:0] green_level,
  output logic [LevelW-1:0] blue_level
);

  front_out_t front;
  logic       accept;

  // Always ready
  assign busy   = 1'b0;
  assign accept = start && !busy;

  hsvrgb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (accept),
    .hue_degrees    (hue_degrees),
    .saturation_pct (saturation_pct),
    .value_pct      (value_pct),
    .front_out      (front)
  );

  hsvrgb_mix u_mix (
    .clk         (clk),
    .rst         (rst),
    .front_in    (front),
    .done        (done),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level)
  );

endmodule

@@ rtl/hsvrgb_checker.sv @@
module hsvrgb_checker
  import hsvrgb_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [PctW-1:0]   saturation_pct,
  input logic [PctW-1:0]   value_pct,
  input logic              done,
  input logic [LevelW-1:0] red_level,
  input logic [LevelW-1:0] green_level,
  input logic [LevelW-1:0] blue_level
);

  // Every accepted item shows up as a result strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 done)
    else $error("accepted item did not produce a result after six cycles");

  // No result without a matching earlier input transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 6))
    else $error("result strobe without a matching input transfer");

  // Zero brightness gives black
  a_black: assert property (@(posedge clk) disable iff (rst)
    (done && $past(value_pct, 6) == '0) |->
      (red_level == '0 && green_level == '0 && blue_level == '0))
    else $error("zero value did not give black");

  // Zero saturation gives a gray level
  a_gray: assert property (@(posedge clk) disable iff (rst)
    (done && $past(saturation_pct, 6) == '0) |->
      (red_level == green_level && green_level == blue_level))
    else $error("zero saturation did not give equal channels");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .saturation_pct (saturation_pct),
  .value_pct      (value_pct),
  .done           (done),
  .red_level      (red_level),
  .green_level    (green_level),
  .blue_level     (blue_level)
);

@@ test/tb_hsv_to_rgb_converter.sv @@
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;
  import hsvrgb_pkg::*;

  localparam int HueTurn      = 360;
  localparam int SectorSpan   = 60;
  localparam int LevelFull    = 255;
  localparam int DrainCycles  = 12;
  localparam int CycleLimit   = 200000;
  localparam int RandomPixels = 550;
  localparam int NumPhases    = 4;

  typedef struct packed {
    logic [HueW-1:0]   hue;
    logic [PctW-1:0]   sat;
    logic [PctW-1:0]   val;
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } pixel_t;

  // Scoreboard: predicts the RGB triple of each accepted pixel, checks results in order
  class rgb_scoreboard;
    pixel_t expected_rgb_q[$];
    int     pixels_in;
    int     results_checked;
    int     mismatches;
    int     clamped_inputs;

    function new();
      pixels_in       = 0;
      results_checked = 0;
      mismatches      = 0;
      clamped_inputs  = 0;
    endfunction

    // Six-sector integer HSV to RGB, truncating division throughout
    function pixel_t calc_rgb(logic [HueW-1:0] hue, logic [PctW-1:0] sat,
                              logic [PctW-1:0] val);
      pixel_t      px;
      int unsigned h, s, v, top, bot, offset, ramp;
      sector_t     sector;
      px.hue = hue;
      px.sat = sat;
      px.val = val;
      h      = 32'(hue) % HueTurn;
      s      = (sat > PCT_FULL) ? 32'(PCT_FULL) : 32'(sat);
      v      = (val > PCT_FULL) ? 32'(PCT_FULL) : 32'(val);
      top    = (v * LevelFull) / PCT_FULL;
      bot    = (top * (PCT_FULL - s)) / PCT_FULL;
      sector = sector_t'(h / SectorSpan);
      offset = h % SectorSpan;
      ramp   = ((top - bot) * offset) / SectorSpan;
      case (sector)
        SEC_RED_YEL: begin
          px.red   = LevelW'(top);
          px.green = LevelW'(bot + ramp);
          px.blue  = LevelW'(bot);
        end
        SEC_YEL_GRN: begin
          px.red   = LevelW'(top - ramp);
          px.green = LevelW'(top);
          px.blue  = LevelW'(bot);
        end
        SEC_GRN_CYN: begin
          px.red   = LevelW'(bot);
          px.green = LevelW'(top);
          px.blue  = LevelW'(bot + ramp);
        end
        SEC_CYN_BLU: begin
          px.red   = LevelW'(bot);
          px.green = LevelW'(top - ramp);
          px.blue  = LevelW'(top);
        end
        SEC_BLU_MAG: begin
          px.red   = LevelW'(bot + ramp);
          px.green = LevelW'(bot);
          px.blue  = LevelW'(top);
        end
        default: begin
          px.red   = LevelW'(top);
          px.green = LevelW'(bot);
          px.blue  = LevelW'(top - ramp);
        end
      endcase
      return px;
    endfunction

    function void note_pixel(logic [HueW-1:0] hue, logic [PctW-1:0] sat,
                             logic [PctW-1:0] val);
      expected_rgb_q.push_back(calc_rgb(hue, sat, val));
      pixels_in++;
      if (sat > PCT_FULL || val > PCT_FULL) clamped_inputs++;
    endfunction

    function void report_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $time, what);
    endfunction

    function void check_rgb(logic [LevelW-1:0] red, logic [LevelW-1:0] green,
                            logic [LevelW-1:0] blue);
      pixel_t px;
      if (expected_rgb_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d", red, green, blue));
        return;
      end
      px = expected_rgb_q.pop_front();
      results_checked++;
      if (red !== px.red || green !== px.green || blue !== px.blue)
        report_mismatch($sformatf(
          "h=%0d s=%0d v=%0d expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
          px.hue, px.sat, px.val, px.red, px.green, px.blue, red, green, blue));
    endfunction

    function int pending();
      return expected_rgb_q.size();
    endfunction

    // Anything still queued at the end never came out
    function void flush_leftovers();
      while (expected_rgb_q.size() != 0) begin
        pixel_t px;
        px = expected_rgb_q.pop_front();
        report_mismatch($sformatf("no result for h=%0d s=%0d v=%0d", px.hue, px.sat, px.val));
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [HueW-1:0]   hue_degrees;
  logic [PctW-1:0]   saturation_pct;
  logic [PctW-1:0]   value_pct;
  logic              done;
  logic [LevelW-1:0] red_level;
  logic [LevelW-1:0] green_level;
  logic [LevelW-1:0] blue_level;

  rgb_scoreboard sb;
  int            cycle_count;

  hsv_to_rgb_converter i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .hue_degrees    (hue_degrees),
    .saturation_pct (saturation_pct),
    .value_pct      (value_pct),
    .done           (done),
    .red_level      (red_level),
    .green_level    (green_level),
    .blue_level     (blue_level)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Input transfers and results, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_pixel(hue_degrees, saturation_pct, value_pct);
    if (!rst && done) sb.check_rgb(red_level, green_level, blue_level);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Present one pixel at the falling edge and hold it until the transfer
  task automatic send_pixel(logic [HueW-1:0] hue, logic [PctW-1:0] sat,
                            logic [PctW-1:0] val);
    @(negedge clk);
    start          <= 1'b1;
    hue_degrees    <= hue;
    saturation_pct <= sat;
    value_pct      <= val;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk);
    start          <= 1'b0;
    hue_degrees    <= HueW'($urandom);
    saturation_pct <= PctW'($urandom);
    value_pct      <= PctW'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] val;
    int              gap_pct;
    int              directed_count;
    pixel_t          directed[$];

    sb             = new();
    cycle_count    = 0;
    clk            = 1'b0;
    rst            = 1'b1;
    start          = 1'b0;
    hue_degrees    = '0;
    saturation_pct = '0;
    value_pct      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every sector boundary, hue wrap, clamping, field extremes
    directed = '{
      '{16'd0,     7'd100, 7'd100, 8'd0, 8'd0, 8'd0},
      '{16'd59,    7'd100, 7'd100, 8'd0, 8'd0, 8'd0},
      '{16'd60,    7'd100, 7'd100, 8'd0, 8'd0, 8'd0},
      '{16'd120,   7'd100, 7'd100, 8'd0, 8'd0, 8'd0},
      '{16'd180,   7'd100, 7'd100, 8'd0, 8'd0, 8'd0},
      '{16'd240,   7'd100, 7'd100, 8'd0, 8'd0, 8'd0},
      '{16'd300,   7'd100, 7'd100, 8'd0, 8'd0, 8'd0},
      '{16'd359,   7'd100, 7'd100, 8'd0, 8'd0, 8'd0},
      '{16'd360,   7'd127, 7'd127, 8'd0, 8'd0, 8'd0},
      '{16'd65535, 7'd101, 7'd101, 8'd0, 8'd0, 8'd0},
      '{16'd65520, 7'd85,  7'd42,  8'd0, 8'd0, 8'd0},
      '{16'd32768, 7'd127, 7'd127, 8'd0, 8'd0, 8'd0},
      '{16'd30,    7'd0,   7'd100, 8'd0, 8'd0, 8'd0},
      '{16'd90,    7'd50,  7'd0,   8'd0, 8'd0, 8'd0},
      '{16'd45,    7'd127, 7'd1,   8'd0, 8'd0, 8'd0},
      '{16'd719,   7'd100, 7'd50,  8'd0, 8'd0, 8'd0},
      '{16'd150,   7'd1,   7'd127, 8'd0, 8'd0, 8'd0},
      '{16'd210,   7'd99,  7'd99,  8'd0, 8'd0, 8'd0},
      '{16'd270,   7'd73,  7'd37,  8'd0, 8'd0, 8'd0},
      '{16'd330,   7'd64,  7'd64,  8'd0, 8'd0, 8'd0},
      '{16'd299,   7'd0,   7'd0,   8'd0, 8'd0, 8'd0}
    };
    directed_count = directed.size();
    foreach (directed[i]) send_pixel(directed[i].hue, directed[i].sat, directed[i].val);
    // Hold off until the pipe is empty before the random part
    idle_cycles(1);
    wait_drained();

    // Random phases: back to back, heavy sender gaps, moderate gaps, back to back
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        1:       gap_pct = 54;
        2:       gap_pct = 29;
        default: gap_pct = 0;
      endcase
      for (int n = 0; n < RandomPixels / NumPhases; n++) begin
        case ($urandom_range(3))
          0:       hue = HueW'($urandom);
          1:       hue = HueW'($urandom_range(0, HueTurn - 1));
          2:       hue = HueW'(SectorSpan * $urandom_range(0, 1091)
                               + ($urandom_range(1) ? 0 : SectorSpan - 1));
          default: hue = HueW'(65535 - $urandom_range(0, HueTurn - 1));
        endcase
        sat = ($urandom_range(3) == 0) ? PctW'($urandom_range(95, 127))
                                       : PctW'($urandom_range(0, 127));
        val = ($urandom_range(3) == 0) ? PctW'($urandom_range(95, 127))
                                       : PctW'($urandom_range(0, 127));
        send_pixel(hue, sat, val);
        if ($urandom_range(99) < gap_pct) idle_cycles($urandom_range(1, 4));
      end
      idle_cycles(1);
      wait_drained();
    end

    // Let any stray result show up, then close out
    repeat (DrainCycles) @(posedge clk);
    sb.flush_leftovers();

    $display("Sent %0d pixels (%0d directed) under %0d pacing phases, %0d results compared",
             sb.pixels_in, directed_count, NumPhases, sb.results_checked);
    $display("Clamped saturation or value in %0d pixels, %0d mismatches",
             sb.clamped_inputs, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
